// ----- hw/rtl/utf8_last_char_hangul_final_check_top_defines.svh -----
// Assertion macros for the UTF-8 last-character Hangul check block.
`ifndef UTF8_LAST_CHAR_HANGUL_FINAL_CHECK_TOP_DEFINES_SVH
`define UTF8_LAST_CHAR_HANGUL_FINAL_CHECK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under clock and active-low reset.
`define ULHFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under clock and active-low reset.
`define ULHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ULHFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ULHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/ulhfc_pkg.sv -----
// Shared types, constants and decode functions for the UTF-8 last-character block.
package ulhfc_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_CODE  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_CODE  = 8'he0;
    localparam logic [7:0] LEAD4_MASK  = 8'hf8;
    localparam logic [7:0] LEAD4_CODE  = 8'hf0;

    localparam logic [CP_W-1:0] HANGUL_FIRST = 21'h00ac00;
    localparam logic [CP_W-1:0] HANGUL_LAST  = 21'h00d7a3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       word_end;
    } t_in_item;

    typedef struct packed {
        logic            has_final_consonant;
        logic [CP_W-1:0] last_code_point;
    } t_out_item;

    // Trailing bytes a lead byte takes; 0 when not a lead byte.
    function automatic logic [1:0] lead_len(input logic [7:0] b);
        logic [1:0] k;
        k = 2'd0;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            k = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            k = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            k = 2'd3;
        end
        return k;
    endfunction

    function automatic logic [CP_W-1:0] decode(
        input logic [7:0] lead,
        input logic [7:0] t0,
        input logic [7:0] t1,
        input logic [7:0] t2,
        input logic [1:0] n
    );
        logic [CP_W-1:0] cp;
        case (n)
            2'd1:    cp = {10'd0, lead[4:0], t0[5:0]};
            2'd2:    cp = {5'd0, lead[3:0], t0[5:0], t1[5:0]};
            default: cp = {lead[2:0], t0[5:0], t1[5:0], t2[5:0]};
        endcase
        return cp;
    endfunction

    // Re-decode the bytes held after a cut-short lead (at most two of them).
    function automatic logic [CP_W-1:0] rescan(
        input logic [7:0]      b0,
        input logic [7:0]      b1,
        input logic [1:0]      n,
        input logic [CP_W-1:0] last
    );
        logic [CP_W-1:0] r;
        r = last;
        case (n)
            2'd1: begin
                if (b0 < ASCII_LIMIT) r = {13'd0, b0};
            end
            2'd2: begin
                if (lead_len(b0) == 2'd1) begin
                    r = decode(b0, b1, 8'h00, 8'h00, 2'd1);
                end else if (b1 < ASCII_LIMIT) begin
                    r = {13'd0, b1};
                end else if (b0 < ASCII_LIMIT) begin
                    r = {13'd0, b0};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/ulhfc_hangul.sv -----
// Hangul syllable final-consonant test on one code point.
module ulhfc_hangul (
    input  logic [ulhfc_pkg::CP_W-1:0] i_cp,
    output logic                       o_final
);

    logic [ulhfc_pkg::CP_W-1:0] off_full;
    logic [13:0]                off;
    logic [11:0]                q;
    logic [4:0]                 s1;
    logic [3:0]                 s2;
    logic                       in_range;
    logic                       mod28_zero;

    // offset < 11172 fits 14 bits; mod 28 = (mod 4) and (mod 7 of offset/4)
    assign in_range = (i_cp >= ulhfc_pkg::HANGUL_FIRST) && (i_cp <= ulhfc_pkg::HANGUL_LAST);
    assign off_full = i_cp - ulhfc_pkg::HANGUL_FIRST;
    assign off      = off_full[13:0];
    assign q        = off[13:2];

    // 8 == 1 mod 7: fold octal digits
    assign s1 = 5'(q[2:0]) + 5'(q[5:3]) + 5'(q[8:6]) + 5'(q[11:9]);
    assign s2 = 4'(s1[2:0]) + 4'(s1[4:3]);

    assign mod28_zero = (off[1:0] == 2'd0) && ((s2 == 4'd0) || (s2 == 4'd7));
    assign o_final    = in_range && !mod28_zero;

endmodule

// ----- hw/rtl/ulhfc_decoder.sv -----
// Per-byte lenient UTF-8 decode state and end-of-word code point.
module ulhfc_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  ulhfc_pkg::t_in_item        i_item,
    output logic [ulhfc_pkg::CP_W-1:0] o_cp,
    output logic                       o_idle
);

    logic [7:0]                 r_held [3];
    logic [1:0]                 r_held_cnt;
    logic [1:0]                 r_need;
    logic [7:0]                 r_lead;
    logic [ulhfc_pkg::CP_W-1:0] r_last;

    logic [7:0]                 n_held [3];
    logic [1:0]                 n_held_cnt;
    logic [1:0]                 n_need;
    logic [7:0]                 n_lead;
    logic [ulhfc_pkg::CP_W-1:0] n_last;
    logic [7:0]                 b;
    logic [1:0]                 k;

    assign b = i_item.text_byte;
    assign k = ulhfc_pkg::lead_len(b);

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_need     = r_need;
        n_lead     = r_lead;
        n_last     = r_last;
        if (r_need != 2'd0) begin
            case (r_held_cnt)
                2'd0: begin
                    n_held[0] = b;
                end
                2'd1: begin
                    n_held[1] = b;
                end
                2'd2: begin
                    n_held[2] = b;
                end
                default: ;
            endcase
            if (r_held_cnt != 2'd3) n_held_cnt = r_held_cnt + 2'd1;
            if (n_held_cnt >= r_need) begin
                n_last     = ulhfc_pkg::decode(r_lead, n_held[0], n_held[1], n_held[2],
                                               r_need);
                n_need     = 2'd0;
                n_held_cnt = 2'd0;
            end
        end else if (b < ulhfc_pkg::ASCII_LIMIT) begin
            n_last = {13'd0, b};
        end else if (k != 2'd0) begin
            n_lead     = b;
            n_need     = k;
            n_held_cnt = 2'd0;
        end
    end

    // cut-short sequence at word end: drop the lead, re-decode what it held
    assign o_cp = (n_need != 2'd0)
                ? ulhfc_pkg::rescan(n_held[0], n_held[1], n_held_cnt, n_last)
                : n_last;

    assign o_idle = (r_need == 2'd0) && (r_held_cnt == 2'd0) && (r_last == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '{default: 8'h00};
            r_held_cnt <= 2'd0;
            r_need     <= 2'd0;
            r_lead     <= 8'h00;
            r_last     <= '0;
        end else if (i_fire) begin
            if (i_item.word_end) begin
                r_held     <= '{default: 8'h00};
                r_held_cnt <= 2'd0;
                r_need     <= 2'd0;
                r_lead     <= 8'h00;
                r_last     <= '0;
            end else begin
                r_held     <= n_held;
                r_held_cnt <= n_held_cnt;
                r_need     <= n_need;
                r_lead     <= n_lead;
                r_last     <= n_last;
            end
        end
    end

endmodule

// ----- hw/rtl/utf8_last_char_hangul_final_check_top.sv -----
// Top level: UTF-8 word last-character decode with Hangul final-consonant flag.
//
// Bytes of a word arrive one per input transaction, word_end set on the
// final byte, and the block returns one output transaction per word: the
// last code point found by lenient UTF-8 decoding (0 if none) and a flag
// that is set when that code point is a Hangul syllable with a final
// consonant. Throughput is one byte per cycle while the output is not
// stalled: a byte is captured in an input register, its decode step (state
// update, end-of-word re-decode of a cut-short sequence, and the Hangul
// mod-28 test) runs in shallow combinational logic, and the result lands in
// an output register. The final byte's result passes through the input
// register and then the output register before it is visible.
// Bytes that do not end a word produce no output. A stalled output holds
// back the byte stage, and the input is still taken when that stage drains
// in the same cycle. State clears after every word; empty words are never
// sent.
`include "utf8_last_char_hangul_final_check_top_defines.svh"

module utf8_last_char_hangul_final_check_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ulhfc_pkg::t_in_item    i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ulhfc_pkg::t_out_item   o_out_item
);

    // byte stage
    logic                 r_in_vld;
    ulhfc_pkg::t_in_item  r_in_item;

    // result stage
    logic                 r_out_vld;
    ulhfc_pkg::t_out_item r_out_item;
    ulhfc_pkg::t_out_item n_out_item;

    logic                       adv;     // result stage can take a new value
    logic                       fire;    // byte stage processes its byte
    logic [ulhfc_pkg::CP_W-1:0] cp;
    logic                       final_c;
    logic                       dec_idle;
    logic                       out_in_block;  // output code point is a syllable

    assign adv        = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && adv;
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    ulhfc_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_cp    (cp),
        .o_idle  (dec_idle)
    );

    ulhfc_hangul u_hangul (
        .i_cp    (cp),
        .o_final (final_c)
    );

    assign n_out_item.has_final_consonant = final_c;
    assign n_out_item.last_code_point     = cp;

    // only the word's final byte yields a transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= fire && r_in_item.word_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_item.word_end) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    assign out_in_block = (o_out_item.last_code_point >= ulhfc_pkg::HANGUL_FIRST)
                       && (o_out_item.last_code_point <= ulhfc_pkg::HANGUL_LAST);

    // end of word always produces a result next cycle
    `ULHFC_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, fire && r_in_item.word_end, o_out_valid)
    // decode state is clear once a word is finished
    `ULHFC_ASSERT_NEXT(a_state_clears, i_clk, i_rst_n, fire && r_in_item.word_end, dec_idle)
    // flag only for code points inside the Hangul syllable block
    `ULHFC_ASSERT_IMPLY(a_flag_range, i_clk, i_rst_n, o_out_valid && o_out_item.has_final_consonant, out_in_block)
    // a held byte is neither lost nor overwritten while the result stalls
    `ULHFC_ASSERT_NEXT(a_byte_held, i_clk, i_rst_n, r_in_vld && !fire, r_in_vld && $stable(r_in_item))

endmodule

// ----- tb/tb_utf8_last_char_hangul_final_check_top.sv -----
// Testbench for the UTF-8 last-character Hangul final-consonant check block.
//
// Bytes go in one transaction at a time; each word-final byte must yield one
// output transaction. A predictor tracks the decode state per accepted byte
// and queues the expected result. The checker compares every output
// transaction against the oldest queued expectation, field by field.
//
// Stimulus: a short directed table first (ASCII extremes, skipped bytes,
// Hangul range edges, max code point, lead byte last, cut-short sequences).
// The random part that follows is mostly well-formed words with random
// characters, plus noise words and words ending inside a sequence.
// Both sides idle for a random gap before each transaction, with some idle-free stretches.
module tb_utf8_last_char_hangul_final_check_top;
    import ulhfc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 1100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HANGUL_FINALS = 28;
    localparam int NUM_DIRECTED  = 24;

    // Character classes drawn for random words.
    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_HANGUL,
        CH_THREE,
        CH_FOUR
    } char_kind_e;

    // One row of the directed table; known rows carry a typed-in result.
    typedef struct packed {
        logic [7:0]      text_byte;
        logic            word_end;
        logic            known;
        logic            has_final_consonant;
        logic [CP_W-1:0] last_code_point;
    } stim_row_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    utf8_last_char_hangul_final_check_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Predictor state: mirrors the decode state of the block.
    logic [7:0]      held_q [0:2];
    int unsigned     held_n;
    int unsigned     need_n;
    logic [7:0]      lead_q;
    logic [CP_W-1:0] last_cp;

    // Expected results, oldest first.
    t_out_item  expected_results[$];

    stim_row_t  directed_rows [0:NUM_DIRECTED-1];
    int         mismatch_count;
    int         cycle_count;
    int         bytes_sent;
    int         words_sent;
    int         results_checked;
    int         finals_seen;
    bit         steady_in;
    bit         steady_out;

    // Trailing bytes after a lead byte; 0 for anything that is not a lead.
    function automatic int unsigned trail_len(input logic [7:0] b);
        if ((b & LEAD2_MASK) == LEAD2_CODE) return 1;
        if ((b & LEAD3_MASK) == LEAD3_CODE) return 2;
        if ((b & LEAD4_MASK) == LEAD4_CODE) return 3;
        return 0;
    endfunction

    function automatic logic [CP_W-1:0] join_cp(
        input logic [7:0] lead,
        input logic [7:0] t0,
        input logic [7:0] t1,
        input logic [7:0] t2,
        input int unsigned n
    );
        int unsigned cp;
        if (n == 1)
            cp = ((lead & 8'h1f) << 6) | (t0 & 8'h3f);
        else if (n == 2)
            cp = ((lead & 8'h0f) << 12) | ((t0 & 8'h3f) << 6) | (t1 & 8'h3f);
        else
            cp = ((lead & 8'h07) << 18) | ((t0 & 8'h3f) << 12) | ((t1 & 8'h3f) << 6)
                 | (t2 & 8'h3f);
        return cp[CP_W-1:0];
    endfunction

    // Word ended inside a sequence: drop the lead, decode the held bytes again.
    function automatic logic [CP_W-1:0] redecode_held(
        input int unsigned     n,
        input logic [CP_W-1:0] prev
    );
        logic [7:0]      pad [0:5];
        logic [CP_W-1:0] r;
        int unsigned     i;
        int unsigned     k;
        for (int j = 0; j < 6; j++) pad[j] = (j < 3) ? held_q[j] : 8'h00;
        r = prev;
        i = 0;
        while (i < n && i < 3) begin
            k = trail_len(pad[i]);
            if (pad[i] < ASCII_LIMIT) begin
                r = {13'd0, pad[i]};
                i++;
            end else if (k != 0 && i + k < n) begin
                r = join_cp(pad[i], pad[i+1], pad[i+2], pad[i+3], k);
                i += k + 1;
            end else begin
                i++;
            end
        end
        return r;
    endfunction

    function automatic void clear_decode_state();
        for (int j = 0; j < 3; j++) held_q[j] = 8'h00;
        held_n  = 0;
        need_n  = 0;
        lead_q  = 8'h00;
        last_cp = '0;
    endfunction

    // Advance the predictor by one accepted byte; emits on the word-final byte.
    function automatic bit predict_byte(input t_in_item it, output t_out_item res);
        logic [7:0] b;
        b   = it.text_byte;
        res = '0;
        if (need_n != 0) begin
            if (held_n < 3) begin
                held_q[held_n] = b;
                held_n++;
            end
            if (held_n >= need_n) begin
                last_cp = join_cp(lead_q, held_q[0], held_q[1], held_q[2], need_n);
                need_n  = 0;
                held_n  = 0;
            end
        end else if (b < ASCII_LIMIT) begin
            last_cp = {13'd0, b};
        end else if (trail_len(b) != 0) begin
            lead_q = b;
            need_n = trail_len(b);
            held_n = 0;
        end
        if (!it.word_end) return 1'b0;
        if (need_n != 0) last_cp = redecode_held(held_n, last_cp);
        res.last_code_point     = last_cp;
        res.has_final_consonant = (last_cp >= HANGUL_FIRST) && (last_cp <= HANGUL_LAST)
                                  && (((last_cp - HANGUL_FIRST) % HANGUL_FINALS) != 0);
        clear_decode_state();
        return 1'b1;
    endfunction

    // Send one byte transaction. Valid is lowered only for a drawn gap, so
    // back-to-back transactions keep it high. The prediction is taken at the
    // accepting edge; known rows queue the typed-in result instead.
    task automatic send_byte(
        input logic [7:0] b,
        input logic       e,
        input logic       known,
        input t_out_item  typed_res
    );
        int        gap;
        t_in_item  it;
        t_out_item res;
        gap = steady_in ? 0 : $urandom_range(0, 4);
        it.text_byte = b;
        it.word_end  = e;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        if (e) words_sent++;
        if (predict_byte(it, res)) expected_results.push_back(known ? typed_res : res);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Append one well-formed character of the given class to the word.
    function automatic void add_char(input char_kind_e kind, inout logic [7:0] word_q[$]);
        int unsigned cp;
        case (kind)
            CH_ASCII: word_q.push_back(8'($urandom_range(1, 127)));
            CH_TWO: begin
                word_q.push_back(8'($urandom_range(8'hc0, 8'hdf)));
                word_q.push_back(cont_byte());
            end
            CH_HANGUL: begin
                // Edges of the syllable block drawn more often than the middle.
                case ($urandom_range(0, 3))
                    0:       cp = HANGUL_FIRST + $urandom_range(0, 3);
                    1:       cp = HANGUL_LAST - $urandom_range(0, 3);
                    default: cp = HANGUL_FIRST + $urandom_range(0, 11171);
                endcase
                word_q.push_back(8'(8'he0 | (cp >> 12)));
                word_q.push_back(8'(8'h80 | ((cp >> 6) & 8'h3f)));
                word_q.push_back(8'(8'h80 | (cp & 8'h3f)));
            end
            CH_THREE: begin
                word_q.push_back(8'($urandom_range(8'he0, 8'hef)));
                word_q.push_back(cont_byte());
                word_q.push_back(cont_byte());
            end
            default: begin
                word_q.push_back(8'($urandom_range(8'hf0, 8'hf7)));
                word_q.push_back(cont_byte());
                word_q.push_back(cont_byte());
                word_q.push_back(cont_byte());
            end
        endcase
    endfunction

    // Build and send one random word; most are well-formed, the rest are
    // noise bytes or a sequence cut short by the word end.
    task automatic send_random_word();
        logic [7:0]  word_q[$];
        int unsigned style;
        int unsigned nchars;
        logic [7:0]  lead;
        style  = $urandom_range(0, 9);
        nchars = $urandom_range(1, 5);
        for (int c = 0; c < nchars; c++)
            add_char(char_kind_e'($urandom_range(CH_ASCII, CH_FOUR)), word_q);
        if (style == 8) begin
            // Pure noise: any nonzero byte, including stray continuations.
            word_q.delete();
            repeat ($urandom_range(1, 6)) word_q.push_back(8'($urandom_range(1, 255)));
        end else if (style == 9) begin
            // Lead byte followed by too few bytes, any values, then word end.
            lead = 8'($urandom_range(8'hc0, 8'hf7));
            word_q.push_back(lead);
            repeat ($urandom_range(0, trail_len(lead) - 1))
                word_q.push_back(8'($urandom_range(1, 255)));
        end
        steady_in = ($urandom_range(0, 7) == 0);
        foreach (word_q[i])
            send_byte(word_q[i], logic'(i == word_q.size() - 1), 1'b0, '0);
    endtask

    // Receiver: random stall before each output transaction.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
            stall = steady_out ? 0 : $urandom_range(0, 4);
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Checker: every output transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected output transaction: last_code_point=%h",
                       o_out_item.last_code_point);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_item.has_final_consonant) finals_seen++;
                if (o_out_item.has_final_consonant !== want.has_final_consonant) begin
                    $error("has_final_consonant: expected %b, actual %b",
                           want.has_final_consonant, o_out_item.has_final_consonant);
                    mismatch_count++;
                end
                if (o_out_item.last_code_point !== want.last_code_point) begin
                    $error("last_code_point: expected %h, actual %h",
                           want.last_code_point, o_out_item.last_code_point);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb_utf8_last_char_hangul_final_check_top failed");
            $finish;
        end
    end

    initial begin
        // Columns: byte, word end, known, expected flag, expected code point.
        directed_rows = '{
            '{8'h41, 1'b1, 1'b1, 1'b0, 21'h000041},  // plain ASCII
            '{8'h7f, 1'b1, 1'b1, 1'b0, 21'h00007f},  // top of ASCII
            '{8'h80, 1'b1, 1'b1, 1'b0, 21'h000000},  // stray continuation only
            '{8'hff, 1'b1, 1'b1, 1'b0, 21'h000000},  // top byte, never a lead
            '{8'hea, 1'b0, 1'b0, 1'b0, 21'h000000},  // first syllable with final
            '{8'hb0, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'h81, 1'b1, 1'b1, 1'b1, 21'h00ac01},
            '{8'hea, 1'b0, 1'b0, 1'b0, 21'h000000},  // first syllable, no final
            '{8'hb0, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'h80, 1'b1, 1'b1, 1'b0, 21'h00ac00},
            '{8'hed, 1'b0, 1'b0, 1'b0, 21'h000000},  // last syllable of the block
            '{8'h9e, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'ha3, 1'b1, 1'b1, 1'b1, 21'h00d7a3},
            '{8'hf7, 1'b0, 1'b0, 1'b0, 21'h000000},  // largest four-byte value
            '{8'hbf, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'hbf, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'hbf, 1'b1, 1'b1, 1'b0, 21'h1fffff},
            '{8'h78, 1'b0, 1'b0, 1'b0, 21'h000000},  // lead byte as final byte
            '{8'hc3, 1'b1, 1'b0, 1'b0, 21'h000000},
            '{8'he0, 1'b0, 1'b0, 1'b0, 21'h000000},  // cut short, ASCII held
            '{8'h61, 1'b1, 1'b0, 1'b0, 21'h000000},
            '{8'hf0, 1'b0, 1'b0, 1'b0, 21'h000000},  // cut short, 2-byte held
            '{8'hc3, 1'b0, 1'b0, 1'b0, 21'h000000},
            '{8'ha9, 1'b1, 1'b0, 1'b0, 21'h000000}
        };
    end

    initial begin
        t_out_item typed_res;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_item       = '0;
        mismatch_count  = 0;
        cycle_count     = 0;
        bytes_sent      = 0;
        words_sent      = 0;
        results_checked = 0;
        finals_seen     = 0;
        steady_in       = 1'b0;
        steady_out      = 1'b0;
        clear_decode_state();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            typed_res.has_final_consonant = directed_rows[r].has_final_consonant;
            typed_res.last_code_point     = directed_rows[r].last_code_point;
            send_byte(directed_rows[r].text_byte, directed_rows[r].word_end,
                      directed_rows[r].known, typed_res);
        end

        while (bytes_sent < NUM_DIRECTED + RANDOM_BYTES) send_random_word();

        @(negedge i_clk);
        i_in_valid = 1'b0;

        // Drain outstanding results, then a few idle cycles for strays.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d words; %0d results checked, %0d with final consonant",
                 bytes_sent, words_sent, results_checked, finals_seen);
        $display("mismatches: %0d, cycles: %0d", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("tb_utf8_last_char_hangul_final_check_top passed");
        else
            $display("tb_utf8_last_char_hangul_final_check_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ulhfc_pkg.sv
hw/rtl/ulhfc_hangul.sv
hw/rtl/ulhfc_decoder.sv
hw/rtl/utf8_last_char_hangul_final_check_top.sv
tb/tb_utf8_last_char_hangul_final_check_top.sv
